FILE: hdl/dpbfa_pkg.sv
// shared types and constants of the dma pool best fit allocator
package dpbfa_pkg;

  localparam int unsigned POOL_BYTES = 8388608;
  localparam int unsigned MAX_BLOCKS = 2048;
  localparam int unsigned PAGE_LG    = 12;
  localparam int unsigned MIN_LG     = 6;
  localparam int unsigned PAGE_BYTES = 1 << PAGE_LG;
  localparam int unsigned POOL_TOTAL = ((POOL_BYTES + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;

  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned BYTES_W = 24;
  localparam int unsigned START_W = 23;
  localparam int unsigned SIZE_W  = 24;
  localparam int unsigned NEED_W  = 25;
  localparam int unsigned IDX_W   = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W   = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned ENT_W   = 1 + SIZE_W + START_W;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic CFG_VIRT_BASE = 1'b0;
  localparam logic CFG_PHYS_BASE = 1'b1;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_ZERO      = 3'd1,
    ST_FULL      = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_FREED     = 3'd4,
    ST_NOMATCH   = 3'd5,
    ST_TOOLARGE  = 3'd6
  } status_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_ICLR_ALLOC,
    OP_ICLR,
    OP_RD_I,
    OP_A_EVAL,
    OP_WR_BEST,
    OP_WR_NEW,
    OP_RES_ZERO,
    OP_RES_FULL,
    OP_RES_EXH,
    OP_RES_NOMATCH,
    OP_RES_TOOLARGE,
    OP_RES_FREED,
    OP_I_INC,
    OP_WR_FREE,
    OP_LAT_I,
    OP_RD_J,
    OP_J_INC,
    OP_MERGE,
    OP_RD_LAST,
    OP_MOVE
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DEC,
    S_A_RD,
    S_A_EV,
    S_A_END,
    S_F_RD,
    S_F_EV,
    S_M_START,
    S_M_RDI,
    S_M_EVI,
    S_M_RDJ,
    S_M_EVJ,
    S_M_RDL,
    S_M_MOV,
    S_OUT
  } state_e;

  typedef struct packed {
    logic is_free;
    logic is_zero;
    logic addr_zero;
    logic i_end;
    logic j_end;
    logic found;
    logic full;
    logic exhaust;
    logic hit;
    logic too_large;
    logic rd_used;
    logic mergeable;
  } dp_sts_t;

endpackage

FILE: hdl/dpbfa_ctrl.sv
// control state machine sequencing table scans, frees and merges
module dpbfa_ctrl import dpbfa_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_fire_i,
  input  logic    out_fire_i,
  input  dp_sts_t sts_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  output dp_op_e  op_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (in_fire_i) state_d = S_DEC;
      S_DEC: begin
        if (sts_i.is_free) state_d = sts_i.addr_zero ? S_OUT : S_F_RD;
        else state_d = sts_i.is_zero ? S_OUT : S_A_RD;
      end
      S_A_RD:    state_d = sts_i.i_end ? S_A_END : S_A_EV;
      S_A_EV:    state_d = S_A_RD;
      S_A_END:   state_d = S_OUT;
      S_F_RD:    state_d = sts_i.i_end ? S_OUT : S_F_EV;
      S_F_EV: begin
        if (sts_i.hit) state_d = sts_i.too_large ? S_OUT : S_M_START;
        else state_d = S_F_RD;
      end
      S_M_START: state_d = S_M_RDI;
      S_M_RDI:   state_d = sts_i.i_end ? S_OUT : S_M_EVI;
      S_M_EVI:   state_d = sts_i.rd_used ? S_M_RDI : S_M_RDJ;
      S_M_RDJ:   state_d = sts_i.j_end ? S_M_RDI : S_M_EVJ;
      S_M_EVJ:   state_d = sts_i.mergeable ? S_M_RDL : S_M_RDJ;
      S_M_RDL:   state_d = S_M_MOV;
      S_M_MOV:   state_d = S_M_START;
      S_OUT:     if (out_fire_i) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    op_o        = OP_NONE;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire_i) op_o = OP_LOAD;
      end
      S_DEC: begin
        if (sts_i.is_free) op_o = sts_i.addr_zero ? OP_RES_NOMATCH : OP_ICLR;
        else op_o = sts_i.is_zero ? OP_RES_ZERO : OP_ICLR_ALLOC;
      end
      S_A_RD:    if (!sts_i.i_end) op_o = OP_RD_I;
      S_A_EV:    op_o = OP_A_EVAL;
      S_A_END: begin
        if (sts_i.found) op_o = OP_WR_BEST;
        else if (sts_i.full) op_o = OP_RES_FULL;
        else if (sts_i.exhaust) op_o = OP_RES_EXH;
        else op_o = OP_WR_NEW;
      end
      S_F_RD:    op_o = sts_i.i_end ? OP_RES_NOMATCH : OP_RD_I;
      S_F_EV: begin
        if (sts_i.hit) op_o = sts_i.too_large ? OP_RES_TOOLARGE : OP_WR_FREE;
        else op_o = OP_I_INC;
      end
      S_M_START: op_o = OP_ICLR;
      S_M_RDI:   op_o = sts_i.i_end ? OP_RES_FREED : OP_RD_I;
      S_M_EVI:   op_o = sts_i.rd_used ? OP_I_INC : OP_LAT_I;
      S_M_RDJ:   op_o = sts_i.j_end ? OP_I_INC : OP_RD_J;
      S_M_EVJ:   op_o = sts_i.mergeable ? OP_MERGE : OP_J_INC;
      S_M_RDL:   op_o = OP_RD_LAST;
      S_M_MOV:   op_o = OP_MOVE;
      S_OUT:     out_valid_o = 1'b1;
      default:   op_o = OP_NONE;
    endcase
  end

endmodule

FILE: hdl/dpbfa_dp.sv
// datapath with block table memory, scan registers and result registers
module dpbfa_dp import dpbfa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_op_e               op_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_sel_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  input  logic                 req_type_i,
  input  logic [BYTES_W-1:0]   req_bytes_i,
  input  logic [ADDR_W-1:0]    free_addr_i,
  output dp_sts_t              sts_o,
  output logic [2:0]           status_o,
  output logic [ADDR_W-1:0]    grant_va_o,
  output logic [ADDR_W-1:0]    phys_addr_o,
  output logic [NEED_W-1:0]    granted_bytes_o
);

  logic [ENT_W-1:0] mem [MAX_BLOCKS];
  logic [ENT_W-1:0] rdata_q;
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_wa, ram_ra;
  logic [ENT_W-1:0] ram_wd;

  logic [ADDR_W-1:0]  vbase_q, pbase_q;
  logic               type_q;
  logic [BYTES_W-1:0] bytes_q;
  logic [ADDR_W-1:0]  addr_q;
  logic               pg_q;
  logic [NEED_W-1:0]  need_q;
  logic [CNT_W-1:0]   idx_q, jdx_q, cnt_q;
  logic [BYTES_W-1:0] bump_q;
  logic [START_W-1:0] ist_q;
  logic [SIZE_W-1:0]  isz_q;
  logic               found_q;
  logic [IDX_W-1:0]   best_idx_q;
  logic [NEED_W-1:0]  best_diff_q;
  logic [START_W-1:0] best_st_q;
  logic [SIZE_W-1:0]  best_sz_q;
  status_e            res_st_q;
  logic [START_W-1:0] res_start_q;
  logic [NEED_W-1:0]  res_size_q;

  logic               rd_used;
  logic [SIZE_W-1:0]  rd_size;
  logic [START_W-1:0] rd_start;
  logic [NEED_W-1:0]  need_calc, diff, off;
  logic [NEED_W:0]    end_off;
  logic [PAGE_LG-1:0] low_sum;
  logic               aligned, better;
  logic [ADDR_W-1:0]  rd_virt;

  assign rd_used  = rdata_q[ENT_W-1];
  assign rd_size  = rdata_q[START_W +: SIZE_W];
  assign rd_start = rdata_q[START_W-1:0];

  always_comb begin
    logic [NEED_W-1:0] b;
    b = {1'b0, req_bytes_i};
    if (req_bytes_i >= BYTES_W'(PAGE_BYTES))
      need_calc = ((b + NEED_W'(PAGE_BYTES - 1)) >> PAGE_LG) << PAGE_LG;
    else
      need_calc = ((b + NEED_W'((1 << MIN_LG) - 1)) >> MIN_LG) << MIN_LG;
  end

  always_comb begin
    logic [NEED_W-1:0] bb;
    bb = {1'b0, bump_q};
    if (pg_q) off = ((bb + NEED_W'(PAGE_BYTES - 1)) >> PAGE_LG) << PAGE_LG;
    else off = ((bb + NEED_W'((1 << MIN_LG) - 1)) >> MIN_LG) << MIN_LG;
  end

  assign end_off = {1'b0, off} + {1'b0, need_q};
  assign low_sum = vbase_q[PAGE_LG-1:0] + rd_start[PAGE_LG-1:0];
  assign aligned = pg_q ? (low_sum == '0) : (low_sum[MIN_LG-1:0] == '0);
  assign diff    = {1'b0, rd_size} - need_q;
  assign better  = !rd_used && ({1'b0, rd_size} >= need_q) && aligned &&
                   (!found_q || diff < best_diff_q);
  assign rd_virt = vbase_q + {{(ADDR_W-START_W){1'b0}}, rd_start};

  always_comb begin
    sts_o.is_free   = type_q == REQ_FREE;
    sts_o.is_zero   = bytes_q == '0;
    sts_o.addr_zero = addr_q == '0;
    sts_o.i_end     = idx_q == cnt_q;
    sts_o.j_end     = jdx_q == cnt_q;
    sts_o.found     = found_q;
    sts_o.full      = cnt_q >= CNT_W'(MAX_BLOCKS);
    sts_o.exhaust   = end_off > (NEED_W+1)'(POOL_TOTAL);
    sts_o.hit       = rd_used && (rd_virt == addr_q);
    sts_o.too_large = (bytes_q != '0) && (bytes_q > rd_size);
    sts_o.rd_used   = rd_used;
    sts_o.mergeable = (jdx_q != idx_q) && !rd_used &&
                      (({1'b0, ist_q} + {1'b0, isz_q[START_W-1:0]}) ==
                       {1'b0, rd_start}) && (isz_q[SIZE_W-1] == 1'b0);
  end

  always_comb begin
    ram_we = 1'b0;
    ram_wa = idx_q[IDX_W-1:0];
    ram_wd = rdata_q;
    ram_re = 1'b0;
    ram_ra = idx_q[IDX_W-1:0];
    case (op_i)
      OP_RD_I: ram_re = 1'b1;
      OP_RD_J: begin
        ram_re = 1'b1;
        ram_ra = jdx_q[IDX_W-1:0];
      end
      OP_RD_LAST: begin
        ram_re = 1'b1;
        ram_ra = cnt_q[IDX_W-1:0];
      end
      OP_WR_BEST: begin
        ram_we = 1'b1;
        ram_wa = best_idx_q;
        ram_wd = {1'b1, best_sz_q, best_st_q};
      end
      OP_WR_NEW: begin
        ram_we = 1'b1;
        ram_wa = cnt_q[IDX_W-1:0];
        ram_wd = {1'b1, need_q[SIZE_W-1:0], off[START_W-1:0]};
      end
      OP_WR_FREE: begin
        ram_we = 1'b1;
        ram_wd = {1'b0, rd_size, rd_start};
      end
      OP_MERGE: begin
        ram_we = 1'b1;
        ram_wd = {1'b0, isz_q + rd_size, ist_q};
      end
      OP_MOVE: begin
        ram_we = 1'b1;
        ram_wa = jdx_q[IDX_W-1:0];
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) mem[ram_wa] <= ram_wd;
    if (ram_re) rdata_q <= mem[ram_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vbase_q <= '0;
      pbase_q <= '0;
      cnt_q   <= '0;
      bump_q  <= '0;
      found_q <= 1'b0;
      idx_q   <= '0;
      jdx_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_sel_i == CFG_VIRT_BASE) vbase_q <= cfg_data_i;
        else pbase_q <= cfg_data_i;
      end
      case (op_i)
        OP_ICLR_ALLOC: begin
          idx_q   <= '0;
          found_q <= 1'b0;
        end
        OP_ICLR:  idx_q <= '0;
        OP_I_INC: idx_q <= idx_q + 1'b1;
        OP_A_EVAL: begin
          idx_q <= idx_q + 1'b1;
          if (better) found_q <= 1'b1;
        end
        OP_WR_NEW: begin
          cnt_q  <= cnt_q + 1'b1;
          bump_q <= end_off[BYTES_W-1:0];
        end
        OP_LAT_I: jdx_q <= '0;
        OP_J_INC: jdx_q <= jdx_q + 1'b1;
        OP_MERGE: cnt_q <= cnt_q - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        type_q  <= req_type_i;
        bytes_q <= req_bytes_i;
        addr_q  <= free_addr_i;
        pg_q    <= req_bytes_i >= BYTES_W'(PAGE_BYTES);
        need_q  <= need_calc;
      end
      OP_A_EVAL: begin
        if (better) begin
          best_idx_q  <= idx_q[IDX_W-1:0];
          best_diff_q <= diff;
          best_st_q   <= rd_start;
          best_sz_q   <= rd_size;
        end
      end
      OP_LAT_I: begin
        ist_q <= rd_start;
        isz_q <= rd_size;
      end
      OP_WR_BEST: begin
        res_st_q    <= ST_GRANTED;
        res_start_q <= best_st_q;
        res_size_q  <= {1'b0, best_sz_q};
      end
      OP_WR_NEW: begin
        res_st_q    <= ST_GRANTED;
        res_start_q <= off[START_W-1:0];
        res_size_q  <= need_q;
      end
      OP_RES_ZERO:     res_st_q <= ST_ZERO;
      OP_RES_FULL:     res_st_q <= ST_FULL;
      OP_RES_EXH:      res_st_q <= ST_EXHAUSTED;
      OP_RES_NOMATCH:  res_st_q <= ST_NOMATCH;
      OP_RES_TOOLARGE: res_st_q <= ST_TOOLARGE;
      OP_RES_FREED:    res_st_q <= ST_FREED;
      default: ;
    endcase
  end

  always_comb begin
    status_o        = res_st_q;
    grant_va_o      = '0;
    phys_addr_o     = '0;
    granted_bytes_o = '0;
    if (res_st_q == ST_GRANTED) begin
      grant_va_o      = vbase_q + {{(ADDR_W-START_W){1'b0}}, res_start_q};
      phys_addr_o     = pbase_q + {{(ADDR_W-START_W){1'b0}}, res_start_q};
      granted_bytes_o = res_size_q;
    end
  end

endmodule

FILE: hdl/dma_pool_best_fit_allocator.sv
// top level of the dma pool best fit allocator
//
//  channel  | direction | handshake               | payload
//  s_axis   | in        | s_axis_tvalid/tready    | tdata, tuser
//  m_axis   | out       | m_axis_tvalid/tready    | tdata, tuser
//  cfg      | in        | cfg_valid_i/cfg_ready_o | cfg_addr_i, cfg_data_i
//
// one request at a time; the block table is a 2048 entry memory with separate read and
// write ports, scanned entry by entry with a read state and an evaluate state for each
// a free scans the same way for the match and then runs merge passes over entry pairs,
// one pass per merge performed and a final one
// the table needs no clearing pass after reset: only entries below count are read
// the result is held on m_axis until taken
module dma_pool_best_fit_allocator import dpbfa_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [71:0]   s_axis_tdata,   // req_bytes, free_addr
  input  logic          s_axis_tuser,   // req_type
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [127:0]  m_axis_tdata,   // virtual address, phys_addr, granted_bytes, zero fill
  output logic [2:0]    m_axis_tuser,   // status
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_addr_i,
  input  logic [47:0]   cfg_data_i
);

  dp_sts_t            sts;
  dp_op_e             op;
  logic               in_fire, out_fire;
  logic [ADDR_W-1:0]  grant_va, phys_addr;
  logic [NEED_W-1:0]  granted_bytes;

  assign in_fire     = s_axis_tvalid && s_axis_tready;
  assign out_fire    = m_axis_tvalid && m_axis_tready;
  assign cfg_ready_o = 1'b1;

  dpbfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .out_fire_i  (out_fire),
    .sts_i       (sts),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .op_o        (op)
  );

  dpbfa_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .cfg_we_i        (cfg_valid_i),
    .cfg_sel_i       (cfg_addr_i),
    .cfg_data_i      (cfg_data_i),
    .req_type_i      (s_axis_tuser),
    .req_bytes_i     (s_axis_tdata[23:0]),
    .free_addr_i     (s_axis_tdata[71:24]),
    .sts_o           (sts),
    .status_o        (m_axis_tuser),
    .grant_va_o      (grant_va),
    .phys_addr_o     (phys_addr),
    .granted_bytes_o (granted_bytes)
  );

  assign m_axis_tdata = {7'd0, granted_bytes, phys_addr, grant_va};

endmodule
